// File: rtl/nnsc_pkg.sv
// Shared constants, types and helpers for the nearest-neighbor scaler.
package nnsc_pkg;

    localparam int MAX_SOURCE_WIDTH  = 256;
    localparam int MAX_SOURCE_HEIGHT = 256;
    localparam int MAX_TARGET_SIZE   = 4096;

    localparam int STORE_DEPTH = MAX_SOURCE_WIDTH * MAX_SOURCE_HEIGHT;
    localparam int ADDR_W      = $clog2(STORE_DEPTH);
    localparam int FRAME_W     = $clog2(STORE_DEPTH + 1);
    localparam int SX_W        = $clog2(MAX_SOURCE_WIDTH);
    localparam int SY_W        = $clog2(MAX_SOURCE_HEIGHT);
    localparam int SWE_W       = $clog2(MAX_SOURCE_WIDTH + 1);
    localparam int SHE_W       = $clog2(MAX_SOURCE_HEIGHT + 1);
    localparam int CNT_W       = $clog2(MAX_TARGET_SIZE);
    localparam int TWE_W       = $clog2(MAX_TARGET_SIZE + 1);

    localparam int PIX_W    = 24;
    localparam int CHAN_W   = 8;
    localparam int COORD_W  = 12;
    localparam int SRC_REG_W = 9;
    localparam int TGT_REG_W = 13;
    localparam int STEP_W   = 24;
    localparam int FRAC_W   = 16;
    localparam int HALF_Q16 = 32768;
    localparam int PROD_W   = CNT_W + STEP_W;
    localparam int RND_W    = PROD_W + 1;
    localparam int SC_W     = RND_W - FRAC_W;

    localparam int FIFO_DEPTH = 4;
    localparam int FIFO_PTR_W = $clog2(FIFO_DEPTH);
    localparam int FIFO_CNT_W = $clog2(FIFO_DEPTH + 1);

    localparam int DATA_W   = 32;
    localparam int PADDR_W  = 5;
    localparam int REG_IDX_W = 3;

    localparam logic KIND_LOAD = 1'b0;
    localparam logic KIND_EMIT = 1'b1;

    localparam logic [REG_IDX_W-1:0] REG_SOURCE_WIDTH   = 3'd0;
    localparam logic [REG_IDX_W-1:0] REG_SOURCE_HEIGHT  = 3'd1;
    localparam logic [REG_IDX_W-1:0] REG_TARGET_WIDTH   = 3'd2;
    localparam logic [REG_IDX_W-1:0] REG_TARGET_HEIGHT  = 3'd3;
    localparam logic [REG_IDX_W-1:0] REG_X_INVERSE_STEP = 3'd4;
    localparam logic [REG_IDX_W-1:0] REG_Y_INVERSE_STEP = 3'd5;
    localparam logic [REG_IDX_W-1:0] REG_COLOR_MODE     = 3'd6;

    typedef struct packed {
        logic              kind;
        logic [CHAN_W-1:0] red_in;
        logic [CHAN_W-1:0] green_in;
        logic [CHAN_W-1:0] blue_in;
    } t_in_item;

    typedef struct packed {
        logic [CHAN_W-1:0]  red_out;
        logic [CHAN_W-1:0]  green_out;
        logic [CHAN_W-1:0]  blue_out;
        logic [COORD_W-1:0] out_column;
        logic [COORD_W-1:0] out_row;
        logic               row_end;
        logic               frame_end;
    } t_out_item;

    typedef struct packed {
        logic [SRC_REG_W-1:0] source_width;
        logic [SRC_REG_W-1:0] source_height;
        logic [TGT_REG_W-1:0] target_width;
        logic [TGT_REG_W-1:0] target_height;
        logic [STEP_W-1:0]    x_inverse_step;
        logic [STEP_W-1:0]    y_inverse_step;
        logic                 color_mode;
    } t_cfg;

    // one classified item on its way from front to back
    typedef struct packed {
        logic               kind;
        logic [ADDR_W-1:0]  addr;
        logic [PIX_W-1:0]   pixel;
        logic [COORD_W-1:0] column;
        logic [COORD_W-1:0] row;
        logic               row_end;
        logic               frame_end;
        logic               color;
    } t_job;

    // zero counts as one, oversize saturates
    function automatic int bound_dim(int v, int maxv);
        int r;
        if (v == 0) begin
            r = 1;
        end else if (v > maxv) begin
            r = maxv;
        end else begin
            r = v;
        end
        return r;
    endfunction

endpackage

// File: rtl/nnsc_regs.sv
// Configuration register file behind the APB-style port.
module nnsc_regs (
    input  logic                         i_clk,
    input  logic                         i_rst_n,
    input  logic                         psel,
    input  logic                         penable,
    input  logic                         pwrite,
    input  logic [nnsc_pkg::PADDR_W-1:0] paddr,
    input  logic [nnsc_pkg::DATA_W-1:0]  pwdata,
    output logic [nnsc_pkg::DATA_W-1:0]  prdata,
    output logic                         pready,
    output nnsc_pkg::t_cfg               o_cfg
);
    import nnsc_pkg::*;

    t_cfg                 r_cfg;
    logic [REG_IDX_W-1:0] reg_idx;
    logic                 wr_en;

    assign reg_idx = paddr[PADDR_W-1:2];
    assign pready  = 1'b1;
    assign wr_en   = psel && penable && pwrite && pready;
    assign o_cfg   = r_cfg;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.source_width   <= SRC_REG_W'(256);
            r_cfg.source_height  <= SRC_REG_W'(256);
            r_cfg.target_width   <= TGT_REG_W'(256);
            r_cfg.target_height  <= TGT_REG_W'(256);
            r_cfg.x_inverse_step <= STEP_W'(65536);
            r_cfg.y_inverse_step <= STEP_W'(65536);
            r_cfg.color_mode     <= 1'b0;
        end else if (wr_en) begin
            unique case (reg_idx)
                REG_SOURCE_WIDTH:   r_cfg.source_width   <= pwdata[SRC_REG_W-1:0];
                REG_SOURCE_HEIGHT:  r_cfg.source_height  <= pwdata[SRC_REG_W-1:0];
                REG_TARGET_WIDTH:   r_cfg.target_width   <= pwdata[TGT_REG_W-1:0];
                REG_TARGET_HEIGHT:  r_cfg.target_height  <= pwdata[TGT_REG_W-1:0];
                REG_X_INVERSE_STEP: r_cfg.x_inverse_step <= pwdata[STEP_W-1:0];
                REG_Y_INVERSE_STEP: r_cfg.y_inverse_step <= pwdata[STEP_W-1:0];
                REG_COLOR_MODE:     r_cfg.color_mode     <= pwdata[0];
                default: ;
            endcase
        end
    end

    always_comb begin
        unique case (reg_idx)
            REG_SOURCE_WIDTH:   prdata = DATA_W'(r_cfg.source_width);
            REG_SOURCE_HEIGHT:  prdata = DATA_W'(r_cfg.source_height);
            REG_TARGET_WIDTH:   prdata = DATA_W'(r_cfg.target_width);
            REG_TARGET_HEIGHT:  prdata = DATA_W'(r_cfg.target_height);
            REG_X_INVERSE_STEP: prdata = DATA_W'(r_cfg.x_inverse_step);
            REG_Y_INVERSE_STEP: prdata = DATA_W'(r_cfg.y_inverse_step);
            REG_COLOR_MODE:     prdata = DATA_W'(r_cfg.color_mode);
            default:            prdata = '0;
        endcase
    end

endmodule

// File: rtl/nnsc_front.sv
// Front end: accepts items, steps the load and raster counters, maps emit
// positions to source addresses in two registered stages.
module nnsc_front (
    input  logic                            i_clk,
    input  logic                            i_rst_n,
    input  nnsc_pkg::t_cfg                  i_cfg,
    input  logic                            i_in_valid,
    output logic                            o_in_stall,
    input  nnsc_pkg::t_in_item              i_in_data,
    input  logic [nnsc_pkg::FIFO_CNT_W-1:0] i_fifo_count,
    output logic                            o_push,
    output nnsc_pkg::t_job                  o_job
);
    import nnsc_pkg::*;

    typedef struct packed {
        logic               kind;
        logic [ADDR_W-1:0]  load_addr;
        logic [PIX_W-1:0]   pixel;
        logic [COORD_W-1:0] column;
        logic [COORD_W-1:0] row;
        logic               row_end;
        logic               frame_end;
        logic [PROD_W-1:0]  x_prod;
        logic [PROD_W-1:0]  y_prod;
    } t_stage1;

    typedef struct packed {
        logic               kind;
        logic [ADDR_W-1:0]  base;
        logic [SX_W-1:0]    sx;
        logic [PIX_W-1:0]   pixel;
        logic [COORD_W-1:0] column;
        logic [COORD_W-1:0] row;
        logic               row_end;
        logic               frame_end;
    } t_stage2;

    logic [SWE_W-1:0]      sw_eff;
    logic [SHE_W-1:0]      sh_eff;
    logic [TWE_W-1:0]      tw_eff;
    logic [TWE_W-1:0]      th_eff;
    logic [FRAME_W-1:0]    frame_size;

    logic [ADDR_W-1:0]     r_load_pos, n_load_pos;
    logic [CNT_W-1:0]      r_col, n_col;
    logic [CNT_W-1:0]      r_row, n_row;
    logic [FRAME_W-1:0]    load_inc;
    logic [TWE_W-1:0]      col_inc;
    logic [TWE_W-1:0]      row_inc;
    logic                  rend;
    logic                  fend;
    logic                  accept;
    logic [FIFO_CNT_W:0]   in_flight;

    logic                  r_s1_valid;
    t_stage1               r_s1;
    logic                  r_s2_valid;
    t_stage2               r_s2;

    logic [RND_W-1:0]      x_rnd;
    logic [RND_W-1:0]      y_rnd;
    logic [SC_W-1:0]       x_sc;
    logic [SC_W-1:0]       y_sc;
    logic [SX_W-1:0]       sx;
    logic [SY_W-1:0]       sy;
    logic [ADDR_W-1:0]     row_base;

    assign sw_eff = SWE_W'(bound_dim(int'(i_cfg.source_width), MAX_SOURCE_WIDTH));
    assign sh_eff = SHE_W'(bound_dim(int'(i_cfg.source_height), MAX_SOURCE_HEIGHT));
    assign tw_eff = TWE_W'(bound_dim(int'(i_cfg.target_width), MAX_TARGET_SIZE));
    assign th_eff = TWE_W'(bound_dim(int'(i_cfg.target_height), MAX_TARGET_SIZE));
    assign frame_size = FRAME_W'(FRAME_W'(sw_eff) * FRAME_W'(sh_eff));

    // credit check: queue entries plus items still in the two stages
    assign in_flight  = (FIFO_CNT_W+1)'(i_fifo_count) + (FIFO_CNT_W+1)'(r_s1_valid)
                      + (FIFO_CNT_W+1)'(r_s2_valid);
    assign o_in_stall = (in_flight >= (FIFO_CNT_W+1)'(FIFO_DEPTH));
    assign accept     = i_in_valid && !o_in_stall;

    assign load_inc = FRAME_W'(r_load_pos) + FRAME_W'(1);
    assign col_inc  = TWE_W'(r_col) + TWE_W'(1);
    assign row_inc  = TWE_W'(r_row) + TWE_W'(1);
    // a counter left past a shrunk size still ends its row or frame
    assign rend     = (col_inc >= tw_eff);
    assign fend     = rend && (row_inc >= th_eff);

    always_comb begin
        n_load_pos = r_load_pos;
        n_col      = r_col;
        n_row      = r_row;
        if (accept) begin
            if (i_in_data.kind == KIND_LOAD) begin
                n_load_pos = (load_inc >= frame_size) ? '0 : load_inc[ADDR_W-1:0];
            end else if (rend) begin
                n_col = '0;
                n_row = fend ? '0 : row_inc[CNT_W-1:0];
            end else begin
                n_col = col_inc[CNT_W-1:0];
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_load_pos <= '0;
            r_col      <= '0;
            r_row      <= '0;
            r_s1_valid <= 1'b0;
            r_s2_valid <= 1'b0;
        end else begin
            r_load_pos <= n_load_pos;
            r_col      <= n_col;
            r_row      <= n_row;
            r_s1_valid <= accept;
            r_s2_valid <= r_s1_valid;
        end
    end

    // stage 1: classify and form the Q20.16 products
    always_ff @(posedge i_clk) begin
        r_s1.kind      <= i_in_data.kind;
        r_s1.load_addr <= r_load_pos;
        r_s1.pixel     <= {i_in_data.blue_in, i_in_data.green_in, i_in_data.red_in};
        r_s1.column    <= COORD_W'(r_col);
        r_s1.row       <= COORD_W'(r_row);
        r_s1.row_end   <= rend;
        r_s1.frame_end <= fend;
        r_s1.x_prod    <= PROD_W'(r_col) * PROD_W'(i_cfg.x_inverse_step);
        r_s1.y_prod    <= PROD_W'(r_row) * PROD_W'(i_cfg.y_inverse_step);
    end

    // stage 2: round half up, clamp to the last column or row, row base address
    assign x_rnd = RND_W'(r_s1.x_prod) + RND_W'(HALF_Q16);
    assign y_rnd = RND_W'(r_s1.y_prod) + RND_W'(HALF_Q16);
    assign x_sc  = x_rnd[RND_W-1:FRAC_W];
    assign y_sc  = y_rnd[RND_W-1:FRAC_W];
    assign sx    = (x_sc >= SC_W'(sw_eff)) ? SX_W'(sw_eff - SWE_W'(1)) : x_sc[SX_W-1:0];
    assign sy    = (y_sc >= SC_W'(sh_eff)) ? SY_W'(sh_eff - SHE_W'(1)) : y_sc[SY_W-1:0];
    assign row_base = ADDR_W'(ADDR_W'(sy) * ADDR_W'(sw_eff));

    always_ff @(posedge i_clk) begin
        r_s2.kind      <= r_s1.kind;
        r_s2.base      <= (r_s1.kind == KIND_EMIT) ? row_base : r_s1.load_addr;
        r_s2.sx        <= (r_s1.kind == KIND_EMIT) ? sx : '0;
        r_s2.pixel     <= r_s1.pixel;
        r_s2.column    <= r_s1.column;
        r_s2.row       <= r_s1.row;
        r_s2.row_end   <= r_s1.row_end;
        r_s2.frame_end <= r_s1.frame_end;
    end

    assign o_push          = r_s2_valid;
    assign o_job.kind      = r_s2.kind;
    assign o_job.addr      = r_s2.base + ADDR_W'(r_s2.sx);
    assign o_job.pixel     = r_s2.pixel;
    assign o_job.column    = r_s2.column;
    assign o_job.row       = r_s2.row;
    assign o_job.row_end   = r_s2.row_end;
    assign o_job.frame_end = r_s2.frame_end;
    assign o_job.color     = i_cfg.color_mode;

endmodule

// File: rtl/nnsc_fifo.sv
// Short job queue between front and back.
module nnsc_fifo (
    input  logic                            i_clk,
    input  logic                            i_rst_n,
    input  logic                            i_push,
    input  nnsc_pkg::t_job                  i_job,
    input  logic                            i_pop,
    output nnsc_pkg::t_job                  o_job,
    output logic                            o_empty,
    output logic [nnsc_pkg::FIFO_CNT_W-1:0] o_count
);
    import nnsc_pkg::*;

    t_job                  r_mem [FIFO_DEPTH];
    logic [FIFO_PTR_W-1:0] r_wr_ptr;
    logic [FIFO_PTR_W-1:0] r_rd_ptr;
    logic [FIFO_CNT_W-1:0] r_count, n_count;

    assign o_job   = r_mem[r_rd_ptr];
    assign o_empty = (r_count == '0);
    assign o_count = r_count;

    always_comb begin
        n_count = r_count;
        if (i_push && !i_pop) begin
            n_count = r_count + FIFO_CNT_W'(1);
        end else if (!i_push && i_pop) begin
            n_count = r_count - FIFO_CNT_W'(1);
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_count  <= '0;
        end else begin
            r_count <= n_count;
            if (i_push) begin
                r_wr_ptr <= r_wr_ptr + FIFO_PTR_W'(1);
            end
            if (i_pop) begin
                r_rd_ptr <= r_rd_ptr + FIFO_PTR_W'(1);
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_mem[r_wr_ptr] <= i_job;
        end
    end

endmodule

// File: rtl/nnsc_back.sv
// Back end: frame store access and the output register.
module nnsc_back (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_empty,
    input  nnsc_pkg::t_job      i_job,
    output logic                o_pop,
    output logic                o_out_valid,
    input  logic                i_out_stall,
    output nnsc_pkg::t_out_item o_out_data
);
    import nnsc_pkg::*;

    logic [PIX_W-1:0]   r_store [STORE_DEPTH];
    logic               r_out_valid;
    logic [PIX_W-1:0]   r_pix;
    logic [COORD_W-1:0] r_col;
    logic [COORD_W-1:0] r_row;
    logic               r_rend;
    logic               r_fend;
    logic               r_color;
    logic               out_free;

    assign out_free = !r_out_valid || !i_out_stall;
    // loads never touch the output register, so they go on under a stall
    assign o_pop    = !i_empty && ((i_job.kind == KIND_LOAD) || out_free);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (o_pop && i_job.kind == KIND_EMIT) begin
            r_out_valid <= 1'b1;
        end else if (!i_out_stall) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (o_pop) begin
            if (i_job.kind == KIND_LOAD) begin
                r_store[i_job.addr] <= i_job.pixel;
            end else begin
                r_pix   <= r_store[i_job.addr];
                r_col   <= i_job.column;
                r_row   <= i_job.row;
                r_rend  <= i_job.row_end;
                r_fend  <= i_job.frame_end;
                r_color <= i_job.color;
            end
        end
    end

    assign o_out_valid          = r_out_valid;
    assign o_out_data.red_out   = r_pix[CHAN_W-1:0];
    assign o_out_data.green_out = r_color ? r_pix[2*CHAN_W-1:CHAN_W] : '0;
    assign o_out_data.blue_out  = r_color ? r_pix[3*CHAN_W-1:2*CHAN_W] : '0;
    assign o_out_data.out_column = r_col;
    assign o_out_data.out_row   = r_row;
    assign o_out_data.row_end   = r_rend;
    assign o_out_data.frame_end = r_fend;

endmodule

// File: rtl/nearest_neighbor_scaler_core.sv
// Top level of the nearest-neighbor scaler: registers, front, queue, back.
//
//  channel | ports                                   | moves
//  --------+-----------------------------------------+------------------------------
//  input   | i_in_valid, o_in_stall, i_in_data       | load or emit item per transfer
//  output  | o_out_valid, i_out_stall, o_out_data    | one scaled pixel per emit
//  config  | psel, penable, pwrite, paddr, pwdata,   | register write or read
//          | prdata, pready                          |
//
// One item is taken per cycle while the four-entry queue has room; an emit
// result comes out through the two front stages, the queue and the
// frame-store read register in the back.
// Reset is synchronous and clears counters, queue and valid flags at once;
// the frame store is not cleared and holds garbage until loaded.
// An output stall stops only emits in the back; the front keeps taking items
// until the queue credit runs out, then raises o_in_stall.
module nearest_neighbor_scaler_core (
    input  logic                         i_clk,
    input  logic                         i_rst_n,
    input  logic                         i_in_valid,
    output logic                         o_in_stall,
    input  nnsc_pkg::t_in_item           i_in_data,
    output logic                         o_out_valid,
    input  logic                         i_out_stall,
    output nnsc_pkg::t_out_item          o_out_data,
    input  logic                         psel,
    input  logic                         penable,
    input  logic                         pwrite,
    input  logic [nnsc_pkg::PADDR_W-1:0] paddr,
    input  logic [nnsc_pkg::DATA_W-1:0]  pwdata,
    output logic [nnsc_pkg::DATA_W-1:0]  prdata,
    output logic                         pready
);
    import nnsc_pkg::*;

    t_cfg                  cfg;
    logic                  push;
    t_job                  push_job;
    logic                  pop;
    t_job                  head_job;
    logic                  fifo_empty;
    logic [FIFO_CNT_W-1:0] fifo_count;

    nnsc_regs u_regs (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready),
        .o_cfg   (cfg)
    );

    nnsc_front u_front (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_cfg        (cfg),
        .i_in_valid   (i_in_valid),
        .o_in_stall   (o_in_stall),
        .i_in_data    (i_in_data),
        .i_fifo_count (fifo_count),
        .o_push       (push),
        .o_job        (push_job)
    );

    nnsc_fifo u_fifo (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (push),
        .i_job   (push_job),
        .i_pop   (pop),
        .o_job   (head_job),
        .o_empty (fifo_empty),
        .o_count (fifo_count)
    );

    nnsc_back u_back (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_empty     (fifo_empty),
        .i_job       (head_job),
        .o_pop       (pop),
        .o_out_valid (o_out_valid),
        .i_out_stall (i_out_stall),
        .o_out_data  (o_out_data)
    );

    // credit scheme must never push into a full queue
    a_no_overflow: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (push && !pop) |-> (fifo_count != FIFO_CNT_W'(FIFO_DEPTH)))
        else $error("job queue overflow");

    // a new result only comes from a job taken off the queue
    a_result_from_pop: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $rose(o_out_valid) |-> $past(pop))
        else $error("result without queue pop");

    // with an empty queue at most two items are in flight, so input is open
    a_empty_no_stall: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        fifo_empty |-> !o_in_stall)
        else $error("input stalled with empty queue");

    a_frame_end_row_end: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && o_out_data.frame_end) |-> o_out_data.row_end)
        else $error("frame end without row end");

endmodule

// File: tb/sv/tb_top.sv
// Testbench for the nearest-neighbor scaler core: pixel scoreboard and top-level driver.

class scaler_scoreboard;
    logic [nnsc_pkg::SRC_REG_W-1:0] src_w_reg;
    logic [nnsc_pkg::SRC_REG_W-1:0] src_h_reg;
    logic [nnsc_pkg::TGT_REG_W-1:0] tgt_w_reg;
    logic [nnsc_pkg::TGT_REG_W-1:0] tgt_h_reg;
    logic [nnsc_pkg::STEP_W-1:0]    x_step;
    logic [nnsc_pkg::STEP_W-1:0]    y_step;
    logic                           color;

    logic [nnsc_pkg::PIX_W-1:0] pixel_mem [nnsc_pkg::STORE_DEPTH];
    bit                         loaded    [nnsc_pkg::STORE_DEPTH];
    int unsigned                load_pos;
    int unsigned                col;
    int unsigned                row;

    nnsc_pkg::t_out_item expected_pixels [$];
    int                  errors;

    function void reset_state();
        src_w_reg = 9'd256;
        src_h_reg = 9'd256;
        tgt_w_reg = 13'd256;
        tgt_h_reg = 13'd256;
        x_step    = 24'h010000;
        y_step    = 24'h010000;
        color     = 1'b0;
        load_pos  = 0;
        col       = 0;
        row       = 0;
        errors    = 0;
        expected_pixels.delete();
        foreach (loaded[i]) loaded[i] = 1'b0;
    endfunction

    function void set_reg(logic [nnsc_pkg::REG_IDX_W-1:0] idx, logic [31:0] value);
        case (idx)
            nnsc_pkg::REG_SOURCE_WIDTH:   src_w_reg = value[nnsc_pkg::SRC_REG_W-1:0];
            nnsc_pkg::REG_SOURCE_HEIGHT:  src_h_reg = value[nnsc_pkg::SRC_REG_W-1:0];
            nnsc_pkg::REG_TARGET_WIDTH:   tgt_w_reg = value[nnsc_pkg::TGT_REG_W-1:0];
            nnsc_pkg::REG_TARGET_HEIGHT:  tgt_h_reg = value[nnsc_pkg::TGT_REG_W-1:0];
            nnsc_pkg::REG_X_INVERSE_STEP: x_step    = value[nnsc_pkg::STEP_W-1:0];
            nnsc_pkg::REG_Y_INVERSE_STEP: y_step    = value[nnsc_pkg::STEP_W-1:0];
            nnsc_pkg::REG_COLOR_MODE:     color     = value[0];
            default: ;
        endcase
    endfunction

    // zero reads as one, oversize saturates
    function int unsigned clamp_dim(int unsigned v, int unsigned maxv);
        if (v == 0) return 1;
        if (v > maxv) return maxv;
        return v;
    endfunction

    function int unsigned map_axis(int unsigned pos, logic [nnsc_pkg::STEP_W-1:0] step,
                                   int unsigned size);
        longint unsigned s;
        s = pos;
        s = s * step;
        s = (s + nnsc_pkg::HALF_Q16) >> nnsc_pkg::FRAC_W;
        if (s >= size) s = size - 1;
        return s[31:0];
    endfunction

    function int unsigned source_addr();
        int unsigned sw;
        int unsigned sh;
        sw = clamp_dim(src_w_reg, nnsc_pkg::MAX_SOURCE_WIDTH);
        sh = clamp_dim(src_h_reg, nnsc_pkg::MAX_SOURCE_HEIGHT);
        return (map_axis(row, y_step, sh) * sw + map_axis(col, x_step, sw))
               % nnsc_pkg::STORE_DEPTH;
    endfunction

    // true when the next emit would read an entry that has been loaded
    function bit emit_safe();
        return loaded[source_addr()];
    endfunction

    function void note_transfer(nnsc_pkg::t_in_item it);
        int unsigned         frame;
        int unsigned         tw;
        int unsigned         th;
        int unsigned         addr;
        logic [23:0]         px;
        bit                  rend;
        bit                  fend;
        nnsc_pkg::t_out_item want;
        frame = clamp_dim(src_w_reg, nnsc_pkg::MAX_SOURCE_WIDTH)
              * clamp_dim(src_h_reg, nnsc_pkg::MAX_SOURCE_HEIGHT);
        if (it.kind == nnsc_pkg::KIND_LOAD) begin
            addr = load_pos % nnsc_pkg::STORE_DEPTH;
            pixel_mem[addr] = {it.blue_in, it.green_in, it.red_in};
            loaded[addr] = 1'b1;
            load_pos = (load_pos + 1 >= frame) ? 0 : load_pos + 1;
        end else begin
            tw = clamp_dim(tgt_w_reg, nnsc_pkg::MAX_TARGET_SIZE);
            th = clamp_dim(tgt_h_reg, nnsc_pkg::MAX_TARGET_SIZE);
            addr = source_addr();
            px = loaded[addr] ? pixel_mem[addr] : '0;
            // a counter left past a shrunk size ends its row or frame right here
            rend = (col + 1 >= tw);
            fend = rend && (row + 1 >= th);
            want.red_out    = px[7:0];
            want.green_out  = color ? px[15:8] : 8'd0;
            want.blue_out   = color ? px[23:16] : 8'd0;
            want.out_column = nnsc_pkg::COORD_W'(col);
            want.out_row    = nnsc_pkg::COORD_W'(row);
            want.row_end    = rend;
            want.frame_end  = fend;
            expected_pixels.push_back(want);
            if (rend) begin
                col = 0;
                row = fend ? 0 : row + 1;
            end else begin
                col = col + 1;
            end
        end
    endfunction

    function void compare_field(string name, int unsigned want, int unsigned got);
        if (want != got) begin
            $error("%s mismatch: expected %0d, got %0d", name, want, got);
            errors++;
        end
    endfunction

    function void check_pixel(nnsc_pkg::t_out_item got);
        nnsc_pkg::t_out_item want;
        if (expected_pixels.size() == 0) begin
            $error("output transfer with no pixel pending");
            errors++;
        end else begin
            want = expected_pixels.pop_front();
            compare_field("red_out", want.red_out, got.red_out);
            compare_field("green_out", want.green_out, got.green_out);
            compare_field("blue_out", want.blue_out, got.blue_out);
            compare_field("out_column", want.out_column, got.out_column);
            compare_field("out_row", want.out_row, got.out_row);
            compare_field("row_end", want.row_end, got.row_end);
            compare_field("frame_end", want.frame_end, got.frame_end);
        end
    endfunction

    function void flag_leftover();
        if (expected_pixels.size() != 0) begin
            $error("%0d pixels never came out", expected_pixels.size());
            errors += expected_pixels.size();
        end
    endfunction
endclass

module tb_top;
    import nnsc_pkg::*;

    localparam int WATCHDOG_LIMIT = 3000;
    localparam int DRAIN_CYCLES   = 12;
    localparam int RANDOM_ITEMS   = 260;
    localparam int TAIL_ITEMS     = 60;

    logic                i_clk = 1'b0;
    logic                i_rst_n;
    logic                i_in_valid;
    logic                o_in_stall;
    t_in_item            i_in_data;
    logic                o_out_valid;
    logic                i_out_stall;
    t_out_item           o_out_data;
    logic                psel;
    logic                penable;
    logic                pwrite;
    logic [PADDR_W-1:0]  paddr;
    logic [DATA_W-1:0]   pwdata;
    logic [DATA_W-1:0]   prdata;
    logic                pready;

    scaler_scoreboard sb;
    int  idle_cycles = 0;
    bit  quiet_tail  = 1'b0;
    int  calm_left   = 0;
    int  random_done = 0;

    nearest_neighbor_scaler_core uut (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_in_valid),
        .o_in_stall  (o_in_stall),
        .i_in_data   (i_in_data),
        .o_out_valid (o_out_valid),
        .i_out_stall (i_out_stall),
        .o_out_data  (o_out_data),
        .psel        (psel),
        .penable     (penable),
        .pwrite      (pwrite),
        .paddr       (paddr),
        .pwdata      (pwdata),
        .prdata      (prdata),
        .pready      (pready)
    );

    always begin
        #6 i_clk = 1'b1;
        #6 i_clk = 1'b0;
    end

    // sampled at the rising edge, before the block's registers move
    always @(posedge i_clk) begin
        if (i_rst_n) begin
            if (i_in_valid && !o_in_stall) sb.note_transfer(i_in_data);
            if (o_out_valid && !i_out_stall) sb.check_pixel(o_out_data);
            if ((i_in_valid && !o_in_stall) || (o_out_valid && !i_out_stall)) begin
                idle_cycles = 0;
            end else begin
                idle_cycles++;
            end
        end
    end

    initial begin
        while (idle_cycles < WATCHDOG_LIMIT) @(posedge i_clk);
        $display("DONE: errors detected");
        $finish;
    end

    // receiver stall bursts, with long open stretches now and then
    initial begin
        int run;
        i_out_stall = 1'b0;
        forever begin
            run = ($urandom_range(0, 4) == 0) ? $urandom_range(40, 120) : $urandom_range(1, 20);
            repeat (run) begin
                @(negedge i_clk);
                i_out_stall = 1'b0;
            end
            if (!quiet_tail) begin
                run = $urandom_range(1, 9);
                repeat (run) begin
                    @(negedge i_clk);
                    i_out_stall = 1'b1;
                end
            end
        end
    end

    function automatic logic [7:0] rand_level();
        case ($urandom_range(0, 9))
            0:       return 8'h00;
            1:       return 8'hFF;
            default: return 8'($urandom_range(0, 255));
        endcase
    endfunction

    function automatic int unsigned with_junk(int unsigned v, int w);
        if ($urandom_range(0, 1) == 1) return v | ($urandom() << w);
        return v;
    endfunction

    // called at a falling edge; returns at the falling edge after the transfer
    task automatic send_item(t_in_item it);
        int gap;
        if (!quiet_tail) begin
            if (calm_left > 0) begin
                calm_left--;
            end else if ($urandom_range(0, 9) == 0) begin
                calm_left = $urandom_range(30, 90);
            end else if ($urandom_range(0, 3) == 0) begin
                gap = $urandom_range(1, 9);
                i_in_valid = 1'b0;
                repeat (gap) @(negedge i_clk);
            end
        end
        i_in_valid = 1'b1;
        i_in_data  = it;
        do @(posedge i_clk); while (o_in_stall);
        @(negedge i_clk);
    endtask

    // an emit that would read a never-loaded entry goes out as a load instead
    task automatic feed_item(bit want_emit, logic [7:0] r, logic [7:0] g, logic [7:0] b);
        t_in_item it;
        it.kind     = (want_emit && sb.emit_safe()) ? KIND_EMIT : KIND_LOAD;
        it.red_in   = r;
        it.green_in = g;
        it.blue_in  = b;
        send_item(it);
    endtask

    task automatic run_phase(int items, int emit_pct);
        repeat (items) begin
            feed_item($urandom_range(1, 100) <= emit_pct, rand_level(), rand_level(),
                      rand_level());
        end
    endtask

    task automatic wait_drained();
        i_in_valid = 1'b0;
        while (sb.expected_pixels.size() != 0) @(posedge i_clk);
        // loads leave nothing to wait on, so give the pipeline time to empty
        repeat (DRAIN_CYCLES) @(posedge i_clk);
        @(negedge i_clk);
    endtask

    task automatic write_reg(logic [REG_IDX_W-1:0] idx, logic [DATA_W-1:0] value);
        psel    = 1'b1;
        penable = 1'b0;
        pwrite  = 1'b1;
        paddr   = PADDR_W'({idx, 2'b00});
        pwdata  = value;
        @(negedge i_clk);
        penable = 1'b1;
        do @(posedge i_clk); while (!pready);
        sb.set_reg(idx, value);
        @(negedge i_clk);
        psel    = 1'b0;
        penable = 1'b0;
        pwrite  = 1'b0;
    endtask

    task automatic apply_setting(int unsigned sw, int unsigned sh, int unsigned tw,
                                 int unsigned th, int unsigned xs, int unsigned ys,
                                 int unsigned cm);
        wait_drained();
        write_reg(REG_SOURCE_WIDTH, with_junk(sw, SRC_REG_W));
        write_reg(REG_SOURCE_HEIGHT, with_junk(sh, SRC_REG_W));
        write_reg(REG_TARGET_WIDTH, with_junk(tw, TGT_REG_W));
        write_reg(REG_TARGET_HEIGHT, with_junk(th, TGT_REG_W));
        write_reg(REG_X_INVERSE_STEP, with_junk(xs, STEP_W));
        write_reg(REG_Y_INVERSE_STEP, with_junk(ys, STEP_W));
        write_reg(REG_COLOR_MODE, with_junk(cm, 1));
    endtask

    function automatic int unsigned pick_src_dim();
        case ($urandom_range(0, 9))
            0:       return 0;
            1:       return 256;
            2:       return $urandom_range(257, 511);
            3, 4:    return $urandom_range(13, 40);
            default: return $urandom_range(1, 12);
        endcase
    endfunction

    function automatic int unsigned pick_tgt_dim();
        case ($urandom_range(0, 9))
            0:       return 0;
            1:       return $urandom_range(4097, 8191);
            default: return $urandom_range(1, 40);
        endcase
    endfunction

    function automatic int unsigned pick_step(int unsigned src, int unsigned tgt);
        case ($urandom_range(0, 7))
            0:       return 0;
            1:       return 24'hFFFFFF;
            2:       return $urandom_range(1, 24'hFFFFFF);
            3, 4:    return $urandom_range(24'h002000, 24'h030000);
            default: return ((sb.clamp_dim(src, MAX_SOURCE_WIDTH) << FRAC_W)
                             / sb.clamp_dim(tgt, MAX_TARGET_SIZE)) & 24'hFFFFFF;
        endcase
    endfunction

    task automatic random_setting();
        int unsigned sw;
        int unsigned sh;
        int unsigned tw;
        int unsigned th;
        sw = pick_src_dim();
        sh = pick_src_dim();
        // keep the frame small so loads do not swamp the run
        if (sb.clamp_dim(sw, MAX_SOURCE_WIDTH) * sb.clamp_dim(sh, MAX_SOURCE_HEIGHT) > 640) begin
            sh = $urandom_range(0, 2);
        end
        tw = pick_tgt_dim();
        th = pick_tgt_dim();
        apply_setting(sw, sh, tw, th, pick_step(sw, tw), pick_step(sh, th),
                      $urandom_range(0, 1));
    endtask

    initial begin
        int n;
        sb = new();
        sb.reset_state();
        i_rst_n    = 1'b0;
        i_in_valid = 1'b0;
        i_in_data  = '0;
        psel       = 1'b0;
        penable    = 1'b0;
        pwrite     = 1'b0;
        paddr      = '0;
        pwdata     = '0;
        repeat (9) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n = 1'b1;

        // reset setting, gray mode, darkest and brightest pixels
        feed_item(1'b0, 8'h00, 8'h00, 8'h00);
        feed_item(1'b1, 8'h00, 8'h00, 8'h00);
        feed_item(1'b0, 8'hFF, 8'hFF, 8'hFF);
        feed_item(1'b1, 8'hFF, 8'hFF, 8'hFF);

        // 2x2 source, color, half-step upscale; third load wraps to address zero
        apply_setting(2, 2, 8, 0, 24'h008000, 24'h010000, 1);
        feed_item(1'b0, 8'h12, 8'h34, 8'h56);
        feed_item(1'b0, 8'hA5, 8'h5A, 8'hFF);
        feed_item(1'b0, 8'h01, 8'h80, 8'hFE);
        repeat (5) feed_item(1'b1, rand_level(), rand_level(), rand_level());

        // shrink target width below the running column
        apply_setting(2, 2, 2, 0, 24'h008000, 24'h010000, 1);
        repeat (3) feed_item(1'b1, rand_level(), rand_level(), rand_level());

        // oversize source and target, tiniest step
        apply_setting(300, 0, 8191, 0, 1, 0, 1);
        repeat (3) feed_item(1'b1, rand_level(), rand_level(), rand_level());

        // wide single-row target, then a tall single-column target
        apply_setting(1, 1, 4096, 1, $urandom_range(1, 24'hFFFFFF), $urandom_range(1, 24'hFFFFFF), 1);
        run_phase(60, 97);
        apply_setting(0, 300, 1, 8191, 0, 24'h010000, 0);
        run_phase(60, 97);
        apply_setting(256, 2, 512, 3, 24'h008000, 24'h00AAAA, 0);
        run_phase(80, 60);
        apply_setting(511, 0, 0, 0, 0, 0, 1);
        run_phase(20, 70);

        while (random_done < RANDOM_ITEMS) begin
            if (random_done >= RANDOM_ITEMS - TAIL_ITEMS) quiet_tail = 1'b1;
            random_setting();
            n = quiet_tail ? TAIL_ITEMS : $urandom_range(20, 60);
            run_phase(n, $urandom_range(40, 90));
            random_done += n;
        end

        wait_drained();
        sb.flag_leftover();
        if (sb.errors == 0) begin
            $display("DONE: 0 errors");
        end else begin
            $display("DONE: errors detected");
        end
        $finish;
    end
endmodule

// File: nearest_neighbor_scaler_core.f
rtl/nnsc_pkg.sv
rtl/nnsc_regs.sv
rtl/nnsc_front.sv
rtl/nnsc_fifo.sv
rtl/nnsc_back.sv
rtl/nearest_neighbor_scaler_core.sv
tb/sv/tb_top.sv
